>>> hdl/bcc_pkg.sv
`timescale 1ns / 1ps

package bcc_pkg;

    // Counter and register widths
    localparam int COUNT_WIDTH = 16;
    localparam int CFG_WIDTH   = 16;
    localparam int CMP_WIDTH   = (COUNT_WIDTH > CFG_WIDTH) ? COUNT_WIDTH : CFG_WIDTH;

    // Configuration port
    localparam int CFG_INDEX_WIDTH = 2;
    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_DEBOUNCE_TICKS     = 2'd0,
        CFG_LONG_CLICK_TICKS   = 2'd1,
        CFG_DOUBLE_CLICK_TICKS = 2'd2
    } cfg_index_t;

    localparam logic [CFG_WIDTH-1:0] DEBOUNCE_TICKS_RESET     = 16'd20;
    localparam logic [CFG_WIDTH-1:0] LONG_CLICK_TICKS_RESET   = 16'd1000;
    localparam logic [CFG_WIDTH-1:0] DOUBLE_CLICK_TICKS_RESET = 16'd300;

    // Stream payload widths
    localparam int S_TDATA_WIDTH = 8;
    localparam int M_TDATA_WIDTH = 8;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_PRESSED  = 3'd1,
        PH_RELEASED = 3'd2,
        PH_LONG     = 3'd3,
        PH_SINGLE   = 3'd4,
        PH_HANDLED  = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_SINGLE = 2'd1,
        EV_DOUBLE = 2'd2,
        EV_LONG   = 2'd3
    } event_t;

    typedef struct packed {
        logic [CFG_WIDTH-1:0] debounce_ticks;
        logic [CFG_WIDTH-1:0] long_click_ticks;
        logic [CFG_WIDTH-1:0] double_click_ticks;
    } cfg_t;

    // Result as it is packed into m_tdata, lowest field last here
    typedef struct packed {
        phase_t click_phase;
        logic   confirmed_level;
        event_t click_event;
    } result_t;

endpackage

>>> hdl/bcc_core.sv
`timescale 1ns / 1ps

module bcc_core import bcc_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    tick_en,
    input  logic    raw_level,
    input  cfg_t    cfg,
    output result_t result
);

    logic                   recorded_reg, recorded_next;
    logic [COUNT_WIDTH-1:0] stable_count_reg, stable_count_next;
    logic                   settling_reg, settling_next;
    logic                   confirmed_reg, confirmed_next;
    phase_t                 phase_reg, phase_next;
    logic [COUNT_WIDTH-1:0] press_count_reg, press_count_next;
    logic                   press_timing_reg, press_timing_next;
    event_t                 event_w;

    function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
        sat_inc = (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic logic reached(input logic [COUNT_WIDTH-1:0] cnt,
                                     input logic [CFG_WIDTH-1:0]   thr);
        reached = CMP_WIDTH'(cnt) >= CMP_WIDTH'(thr);
    endfunction

    always_comb begin
        recorded_next     = recorded_reg;
        stable_count_next = stable_count_reg;
        settling_next     = settling_reg;
        confirmed_next    = confirmed_reg;
        phase_next        = phase_reg;
        press_count_next  = press_count_reg;
        press_timing_next = press_timing_reg;
        event_w           = EV_NONE;

        // debounce: edge restarts the count
        if (raw_level != recorded_reg) begin
            recorded_next     = raw_level;
            stable_count_next = '0;
            settling_next     = 1'b1;
        end
        if (settling_next) begin
            stable_count_next = sat_inc(stable_count_next);
            if (reached(stable_count_next, cfg.debounce_ticks)) begin
                confirmed_next = recorded_next;
                settling_next  = 1'b0;
            end
        end

        // press / release timer
        if (press_timing_reg) begin
            press_count_next = sat_inc(press_count_reg);
            if (phase_reg == PH_PRESSED &&
                reached(press_count_next, cfg.long_click_ticks)) begin
                press_timing_next = 1'b0;
                phase_next        = PH_LONG;
            end else if (phase_reg == PH_RELEASED &&
                         reached(press_count_next, cfg.double_click_ticks)) begin
                press_timing_next = 1'b0;
                phase_next        = PH_SINGLE;
            end
        end

        // click machine, first match wins
        priority if (confirmed_next && phase_next == PH_IDLE) begin
            phase_next        = PH_PRESSED;
            press_count_next  = '0;
            press_timing_next = 1'b1;
        end else if (!confirmed_next && phase_next == PH_PRESSED) begin
            phase_next = PH_RELEASED;
        end else if (phase_next == PH_RELEASED && confirmed_next) begin
            press_timing_next = 1'b0;
            event_w           = EV_DOUBLE;
            phase_next        = PH_HANDLED;
        end else if (phase_next == PH_LONG) begin
            event_w    = EV_LONG;
            phase_next = PH_HANDLED;
        end else if (phase_next == PH_SINGLE) begin
            event_w    = EV_SINGLE;
            phase_next = PH_HANDLED;
        end else if (phase_next == PH_HANDLED && !confirmed_next) begin
            phase_next = PH_IDLE;
        end else begin
            phase_next = phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            recorded_reg     <= 1'b0;
            stable_count_reg <= '0;
            settling_reg     <= 1'b0;
            confirmed_reg    <= 1'b0;
            phase_reg        <= PH_IDLE;
            press_count_reg  <= '0;
            press_timing_reg <= 1'b0;
        end else if (tick_en) begin
            recorded_reg     <= recorded_next;
            stable_count_reg <= stable_count_next;
            settling_reg     <= settling_next;
            confirmed_reg    <= confirmed_next;
            phase_reg        <= phase_next;
            press_count_reg  <= press_count_next;
            press_timing_reg <= press_timing_next;
        end
    end

    assign result.click_event     = event_w;
    assign result.confirmed_level = confirmed_next;
    assign result.click_phase     = phase_next;

endmodule

>>> hdl/button_click_classifier.sv
`timescale 1ns / 1ps
// Channel   | dir | beat contents (tdata, lowest bit first)
// ----------+-----+------------------------------------------------------------
// s_        | in  | [0] raw_level, [7:1] zero            - one beat per tick
// m_        | out | [1:0] click_event, [2] confirmed_level, [5:3] click_phase,
//           |     | [7:6] zero                           - one beat per s_ beat
// cfg_wr_*  | in  | index 0 debounce, 1 long click, 2 double click; 3 ignored
//
// One beat in, one beat out. The whole debounce / click update is one level of
// logic between the state registers and the output register, so a new beat is
// taken every cycle unless an m_ stall holds it off; a result shows up the cycle after its input beat.
// s_tready stays high while the output register is empty or being drained, so
// an m_ stall holds the input off only while a result is still waiting.
// aresetn (synchronous, active low) restores the default thresholds, clears
// the debouncer and click state, and empties the output register.

module button_click_classifier import bcc_pkg::*; (
    input  logic                       aclk,
    input  logic                       aresetn,

    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [S_TDATA_WIDTH-1:0]   s_tdata,   // [0] raw_level

    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [M_TDATA_WIDTH-1:0]   m_tdata,   // [1:0] event, [2] level, [5:3] phase

    input  logic                       cfg_wr_en,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_wr_index,
    input  logic [CFG_WIDTH-1:0]       cfg_wr_data
);

    cfg_t    cfg_reg;
    result_t result_w;
    result_t result_reg;
    logic    m_valid_reg;
    logic    s_beat;

    assign s_tready = !m_valid_reg || m_tready;
    assign s_beat   = s_tvalid && s_tready;

    // Threshold registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.debounce_ticks     <= DEBOUNCE_TICKS_RESET;
            cfg_reg.long_click_ticks   <= LONG_CLICK_TICKS_RESET;
            cfg_reg.double_click_ticks <= DOUBLE_CLICK_TICKS_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                CFG_DEBOUNCE_TICKS:     cfg_reg.debounce_ticks     <= cfg_wr_data;
                CFG_LONG_CLICK_TICKS:   cfg_reg.long_click_ticks   <= cfg_wr_data;
                CFG_DOUBLE_CLICK_TICKS: cfg_reg.double_click_ticks <= cfg_wr_data;
                default: ;  // unused index
            endcase
        end
    end

    bcc_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .tick_en   (s_beat),
        .raw_level (s_tdata[0]),
        .cfg       (cfg_reg),
        .result    (result_w)
    );

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_beat) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_beat) begin
            result_reg <= result_w;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {(M_TDATA_WIDTH - $bits(result_t))'(0), result_reg};

endmodule

>>> hdl/bcc_checker.sv
`timescale 1ns / 1ps

module bcc_checker import bcc_pkg::*; (
    input logic                     aclk,
    input logic                     aresetn,
    input logic                     s_tvalid,
    input logic                     s_tready,
    input logic                     m_tvalid,
    input logic                     m_tready,
    input logic [M_TDATA_WIDTH-1:0] m_tdata
);

    // held result must not change while stalled
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed under stall");

    // every input beat yields a result beat next cycle
    a_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("input beat without result");

    // an event is always reported as the machine enters handled
    a_event_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1:0] != EV_NONE |-> m_tdata[5:3] == PH_HANDLED)
        else $error("click event outside handled phase");

    // a double click comes from a second confirmed press
    a_double_level: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1:0] == EV_DOUBLE |-> m_tdata[2])
        else $error("double click with level low");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule

bind button_click_classifier bcc_checker u_bcc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import bcc_pkg::*;

    localparam int  WATCHDOG_LIMIT = 400;  // cycles with no beat on either side
    localparam int  LONG_HOLD      = 50;   // receiver hold-off, enough to fill the block
    localparam int  SETTLE_CYCLES  = 3;    // extra wait after the last result, as margin
    localparam int  REPORT_LIMIT   = 20;   // mismatch lines printed, all are counted
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_UNUSED_INDEX = 2'd3;

    // ---------------------------------------------------------------- DUT I/O
    logic                       aclk         = 1'b0;
    logic                       aresetn      = 1'b0;
    logic                       s_tvalid     = 1'b0;
    logic                       s_tready;
    logic [S_TDATA_WIDTH-1:0]   s_tdata      = '0;   // [0] raw_level
    logic                       m_tvalid;
    logic                       m_tready     = 1'b0;
    logic [M_TDATA_WIDTH-1:0]   m_tdata;             // [1:0] event, [2] level, [5:3] phase
    logic                       cfg_wr_en    = 1'b0;
    logic [CFG_INDEX_WIDTH-1:0] cfg_wr_index = '0;
    logic [CFG_WIDTH-1:0]       cfg_wr_data  = '0;

    button_click_classifier dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------ testbench state
    logic    level_queue[$];         // raw levels waiting to be sent, one per tick
    result_t predicted_reports[$];   // what the block should say for accepted ticks

    int queued_total   = 0;
    int ticks_accepted = 0;
    int results_checked = 0;
    int mismatches     = 0;
    int events_seen[4] = '{0, 0, 0, 0};
    int settings_run   = 0;

    int src_gap_max    = 0;          // sender gap drawn per beat, 0..this
    int sink_stall_max = 0;          // receiver stall drawn per beat, 0..this
    int src_gap        = 0;
    int sink_stall     = 0;
    int hold_requests  = 0;          // bumped by the sequencer to ask for a long hold-off
    int hold_served    = 0;
    int hold_left      = 0;
    int quiet_cycles   = 0;

    logic s_beat_taken = 1'b0;       // handshake seen at the last rising edge
    logic m_beat_taken = 1'b0;

    // ------------------------------------------------- predictor state copy
    cfg_t                   regs;
    logic                   rec_level;
    logic                   settling;
    logic                   conf_level;
    logic                   press_timing;
    logic [COUNT_WIDTH-1:0] stable_cnt;
    logic [COUNT_WIDTH-1:0] press_cnt;
    phase_t                 click_ph;

    // One tick of debounce + click classification; updates the state copy.
    function automatic result_t classify_tick(input logic raw);
        result_t r;
        event_t  ev;
        ev = EV_NONE;

        // raw edge restarts the settle count
        if (raw != rec_level) begin
            rec_level  = raw;
            stable_cnt = '0;
            settling   = 1'b1;
        end

        if (settling) begin
            if (stable_cnt != '1) stable_cnt = stable_cnt + 1'b1;
            if (stable_cnt >= regs.debounce_ticks) begin
                if (rec_level == raw) conf_level = rec_level;
                settling = 1'b0;
            end
        end

        // press/release timer, saturating
        if (press_timing) begin
            if (press_cnt != '1) press_cnt = press_cnt + 1'b1;
            if (click_ph == PH_PRESSED && press_cnt >= regs.long_click_ticks) begin
                press_timing = 1'b0;
                click_ph     = PH_LONG;
            end else if (click_ph == PH_RELEASED &&
                         press_cnt >= regs.double_click_ticks) begin
                press_timing = 1'b0;
                click_ph     = PH_SINGLE;
            end
        end

        // click machine, first match wins
        if (conf_level && click_ph == PH_IDLE) begin
            click_ph     = PH_PRESSED;
            press_cnt    = '0;
            press_timing = 1'b1;
        end else if (!conf_level && click_ph == PH_PRESSED) begin
            click_ph = PH_RELEASED;
        end else if (click_ph == PH_RELEASED && conf_level) begin
            press_timing = 1'b0;
            ev           = EV_DOUBLE;
            click_ph     = PH_HANDLED;
        end else if (click_ph == PH_LONG) begin
            ev       = EV_LONG;
            click_ph = PH_HANDLED;
        end else if (click_ph == PH_SINGLE) begin
            ev       = EV_SINGLE;
            click_ph = PH_HANDLED;
        end else if (click_ph == PH_HANDLED && !conf_level) begin
            click_ph = PH_IDLE;
        end

        r.click_event     = ev;
        r.confirmed_level = conf_level;
        r.click_phase     = click_ph;
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input int got_v, input int want_v);
        if (mismatches < REPORT_LIMIT)
            $display("ERROR: result %0d: %s got %0d, want %0d",
                     results_checked, what, got_v, want_v);
        mismatches++;
    endtask

    // ------------------------------------------------------------- driver
    // Inputs move on the falling edge; a presented beat stays until taken.
    always @(negedge aclk) begin : tick_driver
        if (!s_tvalid || s_beat_taken) begin
            if (src_gap > 0) begin
                src_gap--;
                s_tvalid <= 1'b0;
            end else if (level_queue.size() > 0) begin
                s_tdata  <= {{(S_TDATA_WIDTH-1){1'b0}}, level_queue.pop_front()};
                s_tvalid <= 1'b1;
                src_gap  = $urandom_range(0, src_gap_max);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // ----------------------------------------------------------- receiver
    // Per-beat random stall, plus an occasional long hold-off on request.
    always @(negedge aclk) begin : result_sink
        if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left   = LONG_HOLD;
        end
        if (m_beat_taken) sink_stall = $urandom_range(0, sink_stall_max);
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (sink_stall > 0) begin
            sink_stall--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------ monitor
    // Sampled on the rising edge: check result beats, predict accepted ticks.
    always @(posedge aclk) begin : beat_monitor
        result_t got;
        result_t want;
        s_beat_taken <= aresetn && s_tvalid && s_tready;
        m_beat_taken <= aresetn && m_tvalid && m_tready;

        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[5:0];
            if (predicted_reports.size() == 0) begin
                flag_mismatch("beat with no tick pending, tdata", int'(m_tdata), 0);
            end else begin
                want = predicted_reports.pop_front();
                if (got.click_event !== want.click_event)
                    flag_mismatch("click_event", got.click_event, want.click_event);
                if (got.confirmed_level !== want.confirmed_level)
                    flag_mismatch("confirmed_level", got.confirmed_level,
                                  want.confirmed_level);
                if (got.click_phase !== want.click_phase)
                    flag_mismatch("click_phase", got.click_phase, want.click_phase);
            end
            results_checked++;
        end

        if (aresetn && s_tvalid && s_tready) begin
            want = classify_tick(s_tdata[0]);
            events_seen[want.click_event]++;
            predicted_reports.push_back(want);
            ticks_accepted++;
        end
    end

    // Counts cycles in which no beat moves on either side.
    always @(posedge aclk) begin : stall_watchdog
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no beat for %0d cycles, %0d results outstanding",
                     quiet_cycles, predicted_reports.size());
            $display("Mismatches found");
            $finish;
        end
    end

    // ----------------------------------------------------------- sequencer
    task automatic push_level(input logic lvl);
        level_queue.push_back(lvl);
        queued_total++;
    endtask

    // '1' = high tick, anything else = low tick
    task automatic push_pattern(input string bits);
        for (int i = 0; i < bits.len(); i++) push_level(bits[i] == "1");
    endtask

    // Block is idle: every queued tick taken, every result back, pipe flushed.
    task automatic wait_drained();
        do @(negedge aclk);
        while (ticks_accepted != queued_total || predicted_reports.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
                             input logic [CFG_WIDTH-1:0] val);
        @(negedge aclk);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= val;
        case (idx)
            CFG_DEBOUNCE_TICKS:     regs.debounce_ticks     = val;
            CFG_LONG_CLICK_TICKS:   regs.long_click_ticks   = val;
            CFG_DOUBLE_CLICK_TICKS: regs.double_click_ticks = val;
            default: ;  // unmapped index, block ignores it
        endcase
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Mostly press/release sequences sized around the thresholds, with contact
    // bounce at the edges; the rest is raw noise.
    task automatic queue_clicks(input int n);
        int target;
        int hold_max;
        int rel_max;
        int len;
        target   = queued_total + n;
        hold_max = (regs.long_click_ticks > 120 ? 120 : int'(regs.long_click_ticks)) +
                   (regs.debounce_ticks > 40 ? 40 : int'(regs.debounce_ticks)) + 3;
        rel_max  = (regs.double_click_ticks > 120 ? 120 : int'(regs.double_click_ticks)) +
                   (regs.debounce_ticks > 40 ? 40 : int'(regs.debounce_ticks)) + 3;
        while (queued_total < target) begin
            if ($urandom_range(0, 4) == 0) begin
                len = $urandom_range(1, 8);
                repeat (len) push_level(1'($urandom_range(0, 1)));
            end else begin
                len = $urandom_range(0, 3);
                repeat (len) push_level(1'($urandom_range(0, 1)));
                len = $urandom_range(1, hold_max);
                repeat (len) push_level(1'b1);
                len = $urandom_range(0, 2);
                repeat (len) push_level(1'($urandom_range(0, 1)));
                len = $urandom_range(1, rel_max);
                repeat (len) push_level(1'b0);
            end
        end
        // cut the last sequence so the phase sends exactly n ticks
        while (queued_total > target) begin
            void'(level_queue.pop_back());
            queued_total--;
        end
    endtask

    task automatic run_setting(input logic [CFG_WIDTH-1:0] deb,
                               input logic [CFG_WIDTH-1:0] lng,
                               input logic [CFG_WIDTH-1:0] dbl,
                               input int gap_max, input int stall_max,
                               input int n, input bit long_hold);
        wait_drained();  // sender pauses here until every result is back
        write_reg(CFG_DEBOUNCE_TICKS, deb);
        write_reg(CFG_LONG_CLICK_TICKS, lng);
        write_reg(CFG_DOUBLE_CLICK_TICKS, dbl);
        settings_run++;
        src_gap_max    = gap_max;
        sink_stall_max = stall_max;
        queue_clicks(n);
        // receiver backs off while the sender keeps offering ticks
        if (long_hold) hold_requests++;
    endtask

    initial begin
        regs         = '{DEBOUNCE_TICKS_RESET, LONG_CLICK_TICKS_RESET,
                         DOUBLE_CLICK_TICKS_RESET};
        rec_level    = 1'b0;
        settling     = 1'b0;
        conf_level   = 1'b0;
        press_timing = 1'b0;
        stable_cnt   = '0;
        press_cnt    = '0;
        click_ph     = PH_IDLE;

        repeat (6) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;

        // Reset thresholds: a bouncing start that never confirms.
        settings_run++;
        push_pattern("1101");
        wait_drained();

        // Directed: zero debounce, short timers; a long click, then two single clicks.
        write_reg(CFG_DEBOUNCE_TICKS, 16'd0);
        write_reg(CFG_LONG_CLICK_TICKS, 16'd3);
        write_reg(CFG_DOUBLE_CLICK_TICKS, 16'd2);
        write_reg(CFG_UNUSED_INDEX, 16'hFFFF);
        settings_run++;
        push_pattern("111110");
        push_pattern("1010");
        push_pattern("10000");

        // Random phases: (debounce, long, double, sender gap, receiver stall, ticks, long hold)
        run_setting(16'd1, 16'd8, 16'd5, 0, 0, 150, 1'b0);
        run_setting(16'd3, 16'd20, 16'd10, 7, 7, 200, 1'b1);
        run_setting(16'd0, 16'd0, 16'd0, 7, 0, 100, 1'b0);
        run_setting(16'd2, 16'hFFFF, 16'hFFFF, 0, 7, 120, 1'b0);
        run_setting(16'd5, 16'd40, 16'd25, 7, 7, 250, 1'b1);
        run_setting(16'hFFFF, 16'hFFFF, 16'hFFFF, 3, 3, 80, 1'b0);
        run_setting(16'($urandom_range(1, 4)), 16'($urandom_range(4, 40)),
                    16'($urandom_range(2, 30)),
                    $urandom_range(0, 7), $urandom_range(0, 7), 200, 1'b1);

        wait_drained();

        $display("Checked %0d result beats for %0d ticks over %0d threshold settings",
                 results_checked, ticks_accepted, settings_run);
        $display("Predicted events: %0d single, %0d double, %0d long",
                 events_seen[EV_SINGLE], events_seen[EV_DOUBLE], events_seen[EV_LONG]);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

>>> sim.f
hdl/bcc_pkg.sv
hdl/bcc_core.sv
hdl/button_click_classifier.sv
hdl/bcc_checker.sv
tb/testbench.sv
